/* rtl/core/segrw_pkg.sv */
// ----------------------------------------------------------------------------
// segrw_pkg
// Shared types, constants and the gain code lookup for the exposure and gain
// register writer.
// ----------------------------------------------------------------------------
package segrw_pkg;

    // Configuration register indexes
    localparam logic REG_LINE_TIME   = 1'b0;
    localparam logic REG_FRAME_LINES = 1'b1;

    localparam int LINE_TIME_W   = 20;
    localparam int FRAME_LINES_W = 16;
    localparam int EXPO_W        = 32;
    localparam int GAIN_W        = 10;
    localparam int LINES_W       = 16;
    localparam int ADDR_W        = 16;
    localparam int BYTE_W        = 8;

    localparam logic [LINE_TIME_W-1:0]   LINE_TIME_RST   = 20'd30;
    localparam logic [FRAME_LINES_W-1:0] FRAME_LINES_RST = 16'd750;

    // One quotient bit per divider step
    localparam int DIV_STEPS = EXPO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Sensor register map
    localparam logic [ADDR_W-1:0] ADDR_LINES_HI = 16'h3012;
    localparam logic [ADDR_W-1:0] ADDR_LINES_LO = 16'h3013;
    localparam logic [ADDR_W-1:0] ADDR_GAIN_HI  = 16'h301C;
    localparam logic [ADDR_W-1:0] ADDR_GAIN_LO  = 16'h301D;
    localparam logic [ADDR_W-1:0] ADDR_UPDATE   = 16'h3060;
    localparam logic [BYTE_W-1:0] UPDATE_VALUE  = 8'h02;

    // Write slot within one five-word burst
    typedef enum logic [2:0] {
        WR_LINES_HI = 3'd0,
        WR_LINES_LO = 3'd1,
        WR_GAIN_HI  = 3'd2,
        WR_GAIN_LO  = 3'd3,
        WR_UPDATE   = 3'd4
    } word_sel_t;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      finish;
        logic      commit;
        word_sel_t word;
    } dp_cmd_t;

    typedef struct packed {
        logic match;
    } dp_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] high;
        logic [BYTE_W-1:0] low;
    } gain_code_t;

    function automatic word_sel_t next_word(input word_sel_t w);
        word_sel_t n;
        unique case (w)
            WR_LINES_HI: n = WR_LINES_LO;
            WR_LINES_LO: n = WR_GAIN_HI;
            WR_GAIN_HI:  n = WR_GAIN_LO;
            WR_GAIN_LO:  n = WR_UPDATE;
            default:     n = WR_UPDATE;
        endcase
        return n;
    endfunction

    // Gain step table: six segments of sixteen steps, thresholds (16+i) << seg
    function automatic logic [BYTE_W-1:0] seg_code_high(input logic [2:0] seg);
        logic [BYTE_W-1:0] v;
        unique case (seg)
            3'd4:    v = 8'h01;
            3'd5:    v = 8'h03;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] seg_code_low(input logic [2:0] seg);
        logic [BYTE_W-1:0] v;
        unique case (seg)
            3'd0:    v = 8'h00;
            3'd1:    v = 8'h10;
            3'd2:    v = 8'h30;
            default: v = 8'h70;
        endcase
        return v;
    endfunction

    // Floor match into the step table: segment from the leading one, step
    // from the four bits below it. Gain below one picks the first entry.
    function automatic gain_code_t gain_lookup(input logic [GAIN_W-1:0] g);
        logic [2:0]        seg;
        logic [3:0]        step;
        logic [GAIN_W-1:0] sh;
        gain_code_t        c;
        priority if (g[9]) seg = 3'd5;
        else if (g[8])     seg = 3'd4;
        else if (g[7])     seg = 3'd3;
        else if (g[6])     seg = 3'd2;
        else if (g[5])     seg = 3'd1;
        else               seg = 3'd0;
        sh   = g >> seg;
        step = g[GAIN_W-1:4] == '0 ? 4'd0 : sh[3:0];
        c.high = seg_code_high(seg);
        c.low  = seg_code_low(seg) + {4'd0, step};
        return c;
    endfunction

endpackage

/* rtl/core/sensor_exposure_gain_register_writer_unit.sv */
// ----------------------------------------------------------------------------
// sensor_exposure_gain_register_writer_unit
// Turns an exposure time and a gain into a burst of sensor register writes.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------
//  s_       | in        | tdata: exposure_time[31:0], gain_q4[41:32]
//  m_       | out       | tdata: reg_addr[15:0], reg_data[23:16]; tlast
//  cfg_     | in        | index 0 line_time, index 1 frame_lines
//
//  An item is decided in order: accept, 32 divider steps of the
//  one-bit-per-cycle restoring divider, clamp, compare; then 5 words
//  go out at one per cycle when the sink is ready.
//  An item whose lines and gain code equal the last written ones emits
//  nothing and frees the input after the compare.
//  Reset is synchronous, active low: line_time 30, frame_lines 750, and
//  the last-written state is all ones so the first item always emits.
//  A stalled sink holds the current word; no new word is taken until the
//  burst's final word (tlast) leaves.
// ----------------------------------------------------------------------------
module sensor_exposure_gain_register_writer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic                               cfg_addr,
    input  logic [segrw_pkg::LINE_TIME_W-1:0]  cfg_wdata,
    // input word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,  // exposure_time, gain_q4
    // register write word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,  // reg_addr, reg_data
    output logic                               m_tlast   // last_write
);
    import segrw_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [ADDR_W-1:0] reg_addr;
    logic [BYTE_W-1:0] reg_data;

    // Sequence the work; the datapath only follows commands.
    segrw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Divide, clamp, look up the gain code and hold the burst payload.
    segrw_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .exposure_time (s_tdata[EXPO_W-1:0]),
        .gain_q4       (s_tdata[EXPO_W+GAIN_W-1:EXPO_W]),
        .cmd           (cmd),
        .status        (status),
        .reg_addr      (reg_addr),
        .reg_data      (reg_data),
        .last_write    (m_tlast)
    );

    assign m_tdata = {reg_data, reg_addr};

endmodule

/* rtl/core/segrw_dp.sv */
// ----------------------------------------------------------------------------
// segrw_dp
// Datapath: configuration registers, restoring divider, line clamp, gain
// lookup, last-written state and the register write payload.
// ----------------------------------------------------------------------------
module segrw_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_addr,
    input  logic [segrw_pkg::LINE_TIME_W-1:0]     cfg_wdata,
    input  logic [segrw_pkg::EXPO_W-1:0]          exposure_time,
    input  logic [segrw_pkg::GAIN_W-1:0]          gain_q4,
    input  segrw_pkg::dp_cmd_t                    cmd,
    output segrw_pkg::dp_status_t                 status,
    output logic [segrw_pkg::ADDR_W-1:0]          reg_addr,
    output logic [segrw_pkg::BYTE_W-1:0]          reg_data,
    output logic                                  last_write
);
    import segrw_pkg::*;

    logic [LINE_TIME_W-1:0]   line_time_reg;
    logic [FRAME_LINES_W-1:0] frame_lines_reg;
    logic [LINE_TIME_W-1:0]   rem_reg;
    logic [EXPO_W-1:0]        quo_reg;
    logic                     short_reg;
    gain_code_t               gain_reg;
    logic [LINES_W-1:0]       lines_reg;
    logic [LINES_W-1:0]       prev_lines_reg;
    gain_code_t               prev_gain_reg;

    logic [LINE_TIME_W:0]     shifted;
    logic [LINE_TIME_W:0]     diff;
    logic                     fits;
    logic [EXPO_W-1:0]        lines_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_time_reg   <= LINE_TIME_RST;
            frame_lines_reg <= FRAME_LINES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LINE_TIME:   line_time_reg   <= cfg_wdata;
                REG_FRAME_LINES: frame_lines_reg <= cfg_wdata[FRAME_LINES_W-1:0];
            endcase
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // A zero line time always fits, so the quotient saturates to all ones.
    assign shifted = {rem_reg, quo_reg[EXPO_W-1]};
    assign diff    = shifted - {1'b0, line_time_reg};
    assign fits    = shifted >= {1'b0, line_time_reg};

    assign lines_raw = short_reg ? EXPO_W'(1) : quo_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg   <= '0;
            quo_reg   <= exposure_time;
            short_reg <= exposure_time < {{(EXPO_W-LINE_TIME_W){1'b0}}, line_time_reg};
            gain_reg  <= gain_lookup(gain_q4);
        end else if (cmd.div_step) begin
            rem_reg <= fits ? diff[LINE_TIME_W-1:0] : shifted[LINE_TIME_W-1:0];
            quo_reg <= {quo_reg[EXPO_W-2:0], fits};
        end
        if (cmd.finish) begin
            if (lines_raw >= {{(EXPO_W-FRAME_LINES_W){1'b0}}, frame_lines_reg}) begin
                lines_reg <= frame_lines_reg - 16'd2;
            end else begin
                lines_reg <= lines_raw[LINES_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_lines_reg     <= '1;
            prev_gain_reg.high <= '1;
            prev_gain_reg.low  <= '1;
        end else if (cmd.commit) begin
            prev_lines_reg <= lines_reg;
            prev_gain_reg  <= gain_reg;
        end
    end

    assign status.match = (lines_reg == prev_lines_reg) && (gain_reg == prev_gain_reg);

    always_comb begin
        unique case (cmd.word)
            WR_LINES_HI: begin
                reg_addr = ADDR_LINES_HI;
                reg_data = lines_reg[15:8];
            end
            WR_LINES_LO: begin
                reg_addr = ADDR_LINES_LO;
                reg_data = lines_reg[7:0];
            end
            WR_GAIN_HI: begin
                reg_addr = ADDR_GAIN_HI;
                reg_data = gain_reg.high;
            end
            WR_GAIN_LO: begin
                reg_addr = ADDR_GAIN_LO;
                reg_data = gain_reg.low;
            end
            default: begin
                reg_addr = ADDR_UPDATE;
                reg_data = UPDATE_VALUE;
            end
        endcase
    end

    assign last_write = (cmd.word == WR_UPDATE);

endmodule

/* rtl/core/segrw_ctrl.sv */
// ----------------------------------------------------------------------------
// segrw_ctrl
// Controller: sequences load, divide, clamp, compare and the write burst.
// ----------------------------------------------------------------------------
module segrw_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  segrw_pkg::dp_status_t  status,
    output segrw_pkg::dp_cmd_t     cmd
);
    import segrw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH,
        ST_COMPARE,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    word_sel_t            word_reg;
    logic                 m_tvalid_reg;

    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = m_tvalid_reg;
    assign cmd.load     = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.div_step = (state_reg == ST_DIVIDE);
    assign cmd.finish   = (state_reg == ST_FINISH);
    assign cmd.commit   = (state_reg == ST_COMPARE) && !status.match;
    assign cmd.word     = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            word_reg     <= WR_LINES_HI;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    state_reg <= ST_COMPARE;
                end
                ST_COMPARE: begin
                    if (status.match) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        word_reg     <= WR_LINES_HI;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (word_reg == WR_UPDATE) begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            word_reg <= next_word(word_reg);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_stall_holds_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(word_reg))
        else $error("write slot moved under stall");

    a_burst_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && word_reg == WR_UPDATE |=> !m_tvalid && s_tready)
        else $error("burst did not end after update word");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready during write burst");

endmodule

/* verif/sensor_write_checker.sv */
// ----------------------------------------------------------------------------
// sensor_write_checker
// Passive monitor for the exposure and gain register writer. It follows the
// configuration port and the input channel and predicts the register write
// burst of each accepted word. It then compares every word that leaves the
// result channel, field by field, with the oldest predicted write.
// ----------------------------------------------------------------------------
module sensor_write_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [segrw_pkg::LINE_TIME_W-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [47:0]                       s_tdata,  // exposure_time, gain_q4
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [23:0]                       m_tdata,  // reg_addr, reg_data
    input  logic                              m_tlast,  // last_write
    output int                                pending,
    output int                                mismatches
);
    import segrw_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              is_last;
    } sensor_write_t;

    sensor_write_t write_q[$];

    logic [LINE_TIME_W-1:0]   line_time;
    logic [FRAME_LINES_W-1:0] frame_lines;
    logic [LINES_W-1:0]       sent_lines;
    logic [BYTE_W-1:0]        sent_gain_hi;
    logic [BYTE_W-1:0]        sent_gain_lo;
    int                       fail_count = 0;

    initial begin
        pending    = 0;
        mismatches = 0;
    end

    // Floor match of a Q6.4 gain into the 96-step table; returns {high, low}.
    function automatic logic [15:0] gain_step_code(input logic [GAIN_W-1:0] g);
        int          sel;
        int          seg;
        int          thr;
        logic [7:0]  hi;
        logic [7:0]  lo;
        sel = 0;
        for (int k = 0; k < 96; k++) begin
            thr = (16 + k % 16) << (k / 16);
            if (thr <= g)
                sel = k;
        end
        seg = sel / 16;
        case (seg)
            4:       hi = 8'h01;
            5:       hi = 8'h03;
            default: hi = 8'h00;
        endcase
        case (seg)
            0:       lo = 8'h00;
            1:       lo = 8'h10;
            2:       lo = 8'h30;
            default: lo = 8'h70;
        endcase
        lo = lo + 8'(sel % 16);
        return {hi, lo};
    endfunction

    function automatic void push_write(input logic [ADDR_W-1:0] addr,
                                       input logic [BYTE_W-1:0] data,
                                       input logic is_last);
        sensor_write_t w;
        w.addr    = addr;
        w.data    = data;
        w.is_last = is_last;
        write_q.push_back(w);
    endfunction

    // Lines from exposure, gain code, then the burst unless nothing changed.
    function automatic void predict_burst(input logic [EXPO_W-1:0] expo,
                                          input logic [GAIN_W-1:0] gain);
        logic [31:0]        quot;
        logic [LINES_W-1:0] lines;
        logic [15:0]        code;
        if (expo < {12'd0, line_time})
            quot = 32'd1;
        else if (line_time == '0)
            quot = '1;
        else
            quot = expo / {12'd0, line_time};
        if (quot >= {16'd0, frame_lines})
            lines = frame_lines - 16'd2;
        else
            lines = quot[15:0];
        code = gain_step_code(gain);
        if (lines == sent_lines && code[15:8] == sent_gain_hi && code[7:0] == sent_gain_lo)
            return;
        sent_lines   = lines;
        sent_gain_hi = code[15:8];
        sent_gain_lo = code[7:0];
        push_write(ADDR_LINES_HI, lines[15:8], 1'b0);
        push_write(ADDR_LINES_LO, lines[7:0], 1'b0);
        push_write(ADDR_GAIN_HI, code[15:8], 1'b0);
        push_write(ADDR_GAIN_LO, code[7:0], 1'b0);
        push_write(ADDR_UPDATE, UPDATE_VALUE, 1'b1);
    endfunction

    always @(posedge aclk) begin
        sensor_write_t want;
        if (!aresetn) begin
            line_time    = LINE_TIME_RST;
            frame_lines  = FRAME_LINES_RST;
            sent_lines   = '1;
            sent_gain_hi = '1;
            sent_gain_lo = '1;
            write_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LINE_TIME:   line_time   = cfg_wdata;
                    REG_FRAME_LINES: frame_lines = cfg_wdata[FRAME_LINES_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (write_q.size() == 0) begin
                    $error("unexpected write word: reg_addr %h reg_data %h last_write %b",
                           m_tdata[15:0], m_tdata[23:16], m_tlast);
                    fail_count++;
                end else begin
                    want = write_q.pop_front();
                    if (m_tdata[15:0] !== want.addr) begin
                        $error("reg_addr: expected %h, actual %h", want.addr, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[23:16] !== want.data) begin
                        $error("reg_data: expected %h, actual %h", want.data, m_tdata[23:16]);
                        fail_count++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $error("last_write: expected %b, actual %b", want.is_last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_burst(s_tdata[31:0], s_tdata[41:32]);
        end
        pending    <= write_q.size();
        mismatches <= fail_count;
    end

endmodule

/* verif/tb_sensor_exposure_gain_register_writer_unit.sv */
// ----------------------------------------------------------------------------
// tb_sensor_exposure_gain_register_writer_unit
// Stimulus and verdict for the exposure and gain register writer. A directed
// list hits the field extremes, gain segment edges and suppressed repeats;
// then random words run under several line time / frame length settings,
// including zero line time and tiny frame lengths. The checker beside the
// block predicts and compares every register write word.
// ----------------------------------------------------------------------------
module tb_sensor_exposure_gain_register_writer_unit;
    import segrw_pkg::*;

    localparam int RESET_CYCLES     = 7;
    localparam int SETTLE_CYCLES    = 60;     // covers a silent item still in flight
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE  = 34;
    localparam int NUM_PHASES       = 8;
    localparam int NUM_DIRECTED     = 22;
    localparam int unsigned RUN_LIMIT = 300000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_addr  = REG_LINE_TIME;
    logic [LINE_TIME_W-1:0] cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [47:0]            s_tdata   = '0;   // exposure_time[31:0], gain_q4[41:32]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;          // reg_addr[15:0], reg_data[23:16]
    logic                   m_tlast;          // last_write

    int                     pending;
    int                     mismatches;
    int unsigned            cycle_count = 0;

    // Shared pacing controls between the stimulus and the sink process
    bit                     no_idle   = 1'b0;
    bit                     sink_hold = 1'b0;

    logic [31:0]            last_expo = '0;
    logic [GAIN_W-1:0]      last_gain = '0;
    int unsigned            cur_line_time   = LINE_TIME_RST;
    int unsigned            cur_frame_lines = FRAME_LINES_RST;

    // Directed words at the reset setting (30 units per line, 750 lines):
    // first word always emits, exact repeats and same-code words stay silent,
    // clamp at frame length, gain below one and above the top step, and every
    // segment boundary of the gain table.
    logic [31:0] dir_expo [NUM_DIRECTED] = '{
        32'd0, 32'd0, 32'd29, 32'd60, 32'd60, 32'hFFFF_FFFF, 32'd22470, 32'd22500,
        32'd22499, 32'd30, 32'd31, 32'd90, 32'd90, 32'd120, 32'd120, 32'd150,
        32'd150, 32'd180, 32'hAAAA_AAAA, 32'h5555_5555, 32'd100, 32'd100
    };
    logic [GAIN_W-1:0] dir_gain [NUM_DIRECTED] = '{
        10'd0, 10'd0, 10'd15, 10'd16, 10'd16, 10'd1023, 10'd992, 10'd991,
        10'd31, 10'd32, 10'd63, 10'd64, 10'd127, 10'd128, 10'd255, 10'd256,
        10'd511, 10'd512, 10'h2AA, 10'h155, 10'd1023, 10'd1022
    };

    // Settings per random phase, extremes of both registers among them
    int unsigned phase_line_time [NUM_PHASES] = '{
        30, 1, 1048575, 0, 7, 250, 2, 1
    };
    int unsigned phase_frame_lines [NUM_PHASES] = '{
        1125, 65535, 3, 750, 1, 0, 2, 5000
    };

    sensor_exposure_gain_register_writer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sensor_write_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: give up on a hung handshake or a lost write word
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sink: draw a stall before every word unless no_idle is set; on request, hold off
    // for a long stretch so the block backs up and stalls its input.
    initial begin
        int  stall;
        bit  long_hold;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            long_hold = sink_hold;
            sink_hold = 1'b0;
            if (long_hold)
                stall = SINK_HOLD_CYCLES;
            else if (no_idle)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            // hold ready until a word goes through
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one word after a random gap; keep valid high when no gap follows.
    task automatic offer_exposure(input logic [31:0] expo, input logic [GAIN_W-1:0] gain);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, gain, expo};
        do @(posedge aclk); while (!s_tready);
        last_expo = expo;
        last_gain = gain;
    endtask

    // Drop valid and wait until every predicted write has left the block.
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_register(input logic idx, input logic [LINE_TIME_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Exposure: mostly a line count from zero to just past the frame length,
    // some fully random, some within two lines.
    function automatic logic [31:0] pick_exposure(input int unsigned lt, input int unsigned fl);
        longint unsigned v;
        int unsigned     mode;
        mode = $urandom_range(0, 9);
        if (mode < 2)
            return $urandom;
        if (mode < 4)
            return 32'($urandom_range(0, lt * 2));
        v = longint'($urandom_range(0, fl + 2)) * lt;
        v = v + ((lt == 0) ? 0 : $urandom_range(0, lt - 1));
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // Gain: mostly uniform, some right at a segment edge
    function automatic logic [GAIN_W-1:0] pick_gain();
        int unsigned e;
        if ($urandom_range(0, 9) < 7)
            return 10'($urandom_range(0, 1023));
        e = (1 << $urandom_range(4, 9)) + $urandom_range(0, 2) - 1;
        return (e > 1023) ? 10'd1023 : 10'(e);
    endfunction

    initial begin
        int unsigned       r;
        logic [31:0]       expo;
        logic [GAIN_W-1:0] gain;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_exposure(dir_expo[i], dir_gain[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // reprogram only while the block is idle
            drain_writes();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            write_register(REG_LINE_TIME, phase_line_time[p][LINE_TIME_W-1:0]);
            write_register(REG_FRAME_LINES, phase_frame_lines[p][LINE_TIME_W-1:0]);
            cur_line_time   = phase_line_time[p];
            cur_frame_lines = phase_frame_lines[p];
            // one phase runs back to back with no idling on either side
            no_idle = (p == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 0 && n == 6)
                    sink_hold = 1'b1;
                if (p == 1 && n == 15)
                    drain_writes();
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    // exact repeat: stays silent unless the settings just changed
                    expo = last_expo;
                    gain = last_gain;
                end else if (r < 22) begin
                    expo = last_expo;
                    gain = pick_gain();
                end else begin
                    expo = pick_exposure(cur_line_time, cur_frame_lines);
                    gain = pick_gain();
                end
                offer_exposure(expo, gain);
            end
        end
        no_idle = 1'b0;

        drain_writes();
        // catch any stray word after the last expected one
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/segrw_pkg.sv
rtl/core/segrw_dp.sv
rtl/core/segrw_ctrl.sv
rtl/core/sensor_exposure_gain_register_writer_unit.sv
verif/sensor_write_checker.sv
verif/tb_sensor_exposure_gain_register_writer_unit.sv
